// ----- sv/tcw_pkg.sv -----
package tcw_pkg;

    // operation codes carried on the command channel
    localparam logic [1:0] OP_WRITE_CHAR = 2'd0;
    localparam logic [1:0] OP_SET_CURSOR = 2'd1;
    localparam logic [1:0] OP_CLEAR      = 2'd2;
    localparam logic [1:0] OP_READ_CELL  = 2'd3;

    // control characters and fill values
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_NULL      = 8'h00;
    localparam logic [7:0] ATTR_RESET   = 8'd15;

    // one text cell as kept in the store
    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] attr;
    } t_cell;

endpackage

// ----- sv/tcw_if.sv -----
// command word: operation and operands
interface tcw_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [4:0] target_row;
    logic [6:0] target_col;

    modport source (output valid, operation, char_code, target_row, target_col, input ready);
    modport sink   (input valid, operation, char_code, target_row, target_col, output ready);
endinterface

// response word: cursor position and read cell
interface tcw_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;

    modport source (output valid, cursor_row, cursor_col, cell_char, cell_attr, scrolled,
                    input ready);
    modport sink   (input valid, cursor_row, cursor_col, cell_char, cell_attr, scrolled,
                    output ready);
endinterface

// attribute register write word
interface tcw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- sv/tcw_cell_mem.sv -----
module tcw_cell_mem #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  tcw_pkg::t_cell i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr,
    output tcw_pkg::t_cell o_rdata
);
    import tcw_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tcw_ctrl.sv -----
module tcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_attr,
    tcw_cmd_if.sink         i_cmd,
    tcw_rsp_if.source       o_rsp,
    output logic            o_mem_we,
    output logic [AW-1:0]   o_mem_waddr,
    output tcw_pkg::t_cell  o_mem_wdata,
    output logic            o_mem_re,
    output logic [AW-1:0]   o_mem_raddr,
    input  tcw_pkg::t_cell  i_mem_rdata
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int NW    = $clog2(CELLS + 1);

    localparam logic [RW-1:0] ROW_LAST     = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST     = CW'(COLUMNS - 1);
    localparam logic [NW-1:0] CNT_COLS     = NW'(COLUMNS);
    localparam logic [NW-1:0] CNT_KEEP     = NW'(CELLS - COLUMNS);
    localparam logic [NW-1:0] CNT_LAST     = NW'(CELLS - 1);
    localparam logic [NW-1:0] CNT_END      = NW'(CELLS);

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_READ   = 5'b00100,
        S_SCROLL = 5'b01000,
        S_FILL   = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [NW-1:0] r_cnt, n_cnt;
    t_cell         r_fill, n_fill;
    logic          r_hit, n_hit;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_char, n_out_char;
    logic [7:0]    r_out_attr, n_out_attr;
    logic          r_out_scrolled, n_out_scrolled;

    logic          accept;
    logic          cur_zero;
    logic          tgt_hit;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] tgt_addr;
    logic [NW-1:0] cnt_prev;
    logic [NW-1:0] cnt_src;

    // handshake: idle and the result slot free or draining
    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_cmd.valid && i_cmd.ready;

    // cell addresses
    assign cur_addr = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign tgt_addr = AW'(i_cmd.target_row) * AW'(COLUMNS) + AW'(i_cmd.target_col);
    assign tgt_hit  = (32'(i_cmd.target_row) < ROWS) && (32'(i_cmd.target_col) < COLUMNS);
    assign cur_zero = (r_row == '0) && (r_col == '0);
    assign cnt_prev = r_cnt - NW'(1);
    assign cnt_src  = r_cnt + CNT_COLS;

    // sequencer
    always_comb begin
        n_state        = r_state;
        n_row          = r_row;
        n_col          = r_col;
        n_cnt          = r_cnt;
        n_fill         = r_fill;
        n_hit          = r_hit;
        n_out_valid    = r_out_valid && !o_rsp.ready;
        n_out_char     = r_out_char;
        n_out_attr     = r_out_attr;
        n_out_scrolled = r_out_scrolled;
        o_mem_we       = 1'b0;
        o_mem_waddr    = cur_addr;
        o_mem_wdata    = '0;
        o_mem_re       = 1'b0;
        o_mem_raddr    = tgt_addr;

        unique case (r_state)
            S_INIT, S_FILL: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_cnt[AW-1:0];
                o_mem_wdata = r_fill;
                n_cnt       = r_cnt + NW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                    if (r_state == S_FILL) begin
                        n_out_valid    = 1'b1;
                        n_out_char     = '0;
                        n_out_attr     = '0;
                        n_out_scrolled = 1'b0;
                    end
                end
            end
            S_IDLE: begin
                if (accept) begin
                    // default: immediate result with no cell data
                    n_out_valid    = 1'b1;
                    n_out_char     = '0;
                    n_out_attr     = '0;
                    n_out_scrolled = 1'b0;
                    case (i_cmd.operation)
                        OP_WRITE_CHAR: begin
                            if (i_cmd.char_code == CH_NEWLINE) begin
                                n_col = '0;
                                if (r_row == ROW_LAST) begin
                                    n_out_valid = 1'b0;
                                    n_state     = S_SCROLL;
                                end else begin
                                    n_row = r_row + RW'(1);
                                end
                            end else if (i_cmd.char_code == CH_BACKSPACE) begin
                                if (!cur_zero) begin
                                    o_mem_we    = 1'b1;
                                    o_mem_waddr = cur_addr - AW'(1);
                                    o_mem_wdata = '{ch: CH_NULL, attr: i_attr};
                                    if (r_col == '0) begin
                                        n_col = COL_LAST;
                                        n_row = r_row - RW'(1);
                                    end else begin
                                        n_col = r_col - CW'(1);
                                    end
                                end
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_wdata = '{ch: i_cmd.char_code, attr: i_attr};
                                if (r_col == COL_LAST) begin
                                    n_col = '0;
                                    if (r_row == ROW_LAST) begin
                                        n_out_valid = 1'b0;
                                        n_state     = S_SCROLL;
                                    end else begin
                                        n_row = r_row + RW'(1);
                                    end
                                end else begin
                                    n_col = r_col + CW'(1);
                                end
                            end
                        end
                        OP_SET_CURSOR: begin
                            n_row = (32'(i_cmd.target_row) >= ROWS) ? ROW_LAST
                                                                     : RW'(i_cmd.target_row);
                            n_col = (32'(i_cmd.target_col) >= COLUMNS) ? COL_LAST
                                                                        : CW'(i_cmd.target_col);
                        end
                        OP_CLEAR: begin
                            n_out_valid = 1'b0;
                            n_row       = '0;
                            n_col       = '0;
                            n_cnt       = '0;
                            n_fill      = '{ch: CH_SPACE, attr: i_attr};
                            n_state     = S_FILL;
                        end
                        default: begin
                            // read cell: fetch then answer
                            n_out_valid = 1'b0;
                            n_hit       = tgt_hit;
                            o_mem_re    = tgt_hit;
                            n_state     = S_READ;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out_valid    = 1'b1;
                n_out_char     = r_hit ? i_mem_rdata.ch : '0;
                n_out_attr     = r_hit ? i_mem_rdata.attr : '0;
                n_out_scrolled = 1'b0;
                n_state        = S_IDLE;
            end
            S_SCROLL: begin
                // read cell p + COLUMNS, write cell p - 1 from the previous cycle's read
                o_mem_re    = (r_cnt < CNT_KEEP);
                o_mem_raddr = cnt_src[AW-1:0];
                o_mem_we    = (r_cnt != '0);
                o_mem_waddr = cnt_prev[AW-1:0];
                o_mem_wdata = (r_cnt <= CNT_KEEP) ? i_mem_rdata : '0;
                n_cnt       = r_cnt + NW'(1);
                if (r_cnt == CNT_END) begin
                    n_cnt          = '0;
                    n_state        = S_IDLE;
                    n_out_valid    = 1'b1;
                    n_out_char     = '0;
                    n_out_attr     = '0;
                    n_out_scrolled = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_cnt       <= n_cnt;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hit          <= n_hit;
        r_out_char     <= n_out_char;
        r_out_attr     <= n_out_attr;
        r_out_scrolled <= n_out_scrolled;
    end

    // response word
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cursor_row = 5'(r_row);
    assign o_rsp.cursor_col = 7'(r_col);
    assign o_rsp.cell_char  = r_out_char;
    assign o_rsp.cell_attr  = r_out_attr;
    assign o_rsp.scrolled   = r_out_scrolled;

    // cursor never leaves the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < ROWS) && (32'(r_col) < COLUMNS))
        else $error("cursor outside the screen");

    // scroll copy never writes the cell it reads in the same cycle
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("read and write of the same cell in one cycle");

    // end of the scroll pass answers with the scrolled flag
    a_scroll_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && r_cnt == CNT_END) |=> (r_out_valid && r_out_scrolled))
        else $error("scroll finished without a scrolled response");

    // an accepted read cell goes to the fetch state
    a_read_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.operation == OP_READ_CELL) |=> (r_state == S_READ))
        else $error("read cell did not fetch");

endmodule

// ----- sv/text_console_writer_top.sv -----
// Text console writer: keeps a ROWS x COLUMNS store of character and attribute
// bytes plus a cursor, and takes one command word at a time (write char with
// newline and backspace handling, set cursor, clear, read cell), answering each
// with one response word holding the cursor after the step. Write char, set
// cursor and backspace answer straight from the idle state; read cell first
// passes a fetch state for the registered read of the cell memory. A write or
// newline past the last row scrolls the store up by walking it one cell per
// cycle; clear writes one cell per cycle. After reset the store is swept to
// zero, during which no command word is taken; attribute writes are taken at
// any time.
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcw_cmd_if.sink   i_cmd,
    tcw_rsp_if.source o_rsp,
    tcw_cfg_if.sink   i_cfg
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [7:0]    r_attr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_cell         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_cell         mem_rdata;

    // attribute register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg.valid) begin
            r_attr <= i_cfg.data;
        end
    end

    // command sequencer and cursor
    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_attr      (r_attr),
        .i_cmd       (i_cmd),
        .o_rsp       (o_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // cell store
    tcw_cell_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_cell_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import tcw_pkg::*;

    localparam int CON_COLS  = 80;
    localparam int CON_ROWS  = 25;
    localparam int CON_CELLS = CON_COLS * CON_ROWS;

    // one response word as seen on the output channel
    typedef struct packed {
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] ch;
        logic [7:0] attr;
        logic       scrolled;
    } t_console_rsp;

    // console predictor and response checker
    class console_scoreboard;
        t_cell        cells [CON_CELLS];
        int unsigned  cursor;
        logic [7:0]   attr_reg;
        t_console_rsp expected_rsp [$];
        int           errors;

        function new();
            foreach (cells[i]) cells[i] = '0;
            cursor   = 0;
            attr_reg = ATTR_RESET;
            errors   = 0;
        endfunction

        function void set_attr(logic [7:0] value);
            attr_reg = value;
        endfunction

        // move every row up by one, blank row comes in at the bottom
        function void scroll_up();
            for (int i = 0; i < CON_CELLS - CON_COLS; i++) cells[i] = cells[i + CON_COLS];
            for (int i = CON_CELLS - CON_COLS; i < CON_CELLS; i++) cells[i] = '0;
        endfunction

        // apply one accepted command word and queue the response it should give
        function void note_cmd(logic [1:0] op, logic [7:0] ch, logic [4:0] row,
                               logic [6:0] col);
            t_console_rsp want;
            int unsigned  next;
            int unsigned  r;
            int unsigned  c;
            want = '0;
            r    = row;
            c    = col;
            case (op)
                OP_WRITE_CHAR: begin
                    if (ch == CH_NEWLINE) begin
                        next = (cursor / CON_COLS + 1) * CON_COLS;
                    end else if (ch == CH_BACKSPACE) begin
                        // nothing moves at the first cell
                        next = (cursor == 0) ? 0 : cursor - 1;
                        if (cursor != 0) cells[next] = '{ch: CH_NULL, attr: attr_reg};
                    end else begin
                        cells[cursor] = '{ch: ch, attr: attr_reg};
                        next = cursor + 1;
                    end
                    if (next >= CON_CELLS) begin
                        scroll_up();
                        next -= CON_COLS;
                        want.scrolled = 1'b1;
                    end
                    cursor = next;
                end
                OP_SET_CURSOR: begin
                    if (r >= CON_ROWS) r = CON_ROWS - 1;
                    if (c >= CON_COLS) c = CON_COLS - 1;
                    cursor = r * CON_COLS + c;
                end
                OP_CLEAR: begin
                    foreach (cells[i]) cells[i] = '{ch: CH_SPACE, attr: attr_reg};
                    cursor = 0;
                end
                OP_READ_CELL: begin
                    // out of range reads answer zero
                    if (r < CON_ROWS && c < CON_COLS) begin
                        want.ch   = cells[r * CON_COLS + c].ch;
                        want.attr = cells[r * CON_COLS + c].attr;
                    end
                end
            endcase
            want.row = 5'(cursor / CON_COLS);
            want.col = 7'(cursor % CON_COLS);
            expected_rsp.push_back(want);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 50) $display("mismatch: %s", what);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        // compare a response word with the oldest expectation
        task check_rsp(t_console_rsp got);
            t_console_rsp want;
            if (expected_rsp.size() == 0) begin
                report($sformatf("unexpected response word, cursor %0d,%0d", got.row, got.col));
                return;
            end
            want = expected_rsp.pop_front();
            compare_field("cursor_row", 8'(got.row), 8'(want.row));
            compare_field("cursor_col", 8'(got.col), 8'(want.col));
            compare_field("cell_char", got.ch, want.ch);
            compare_field("cell_attr", got.attr, want.attr);
            compare_field("scrolled", 8'(got.scrolled), 8'(want.scrolled));
        endtask
    endclass

    localparam int     ITEMS         = 850;
    localparam int     DIRECTED      = 25;
    localparam int     PHASES        = 4;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     SETTLE_CYCLES = 8;
    localparam longint CYCLE_LIMIT   =
        2 * (longint'(CON_CELLS) + longint'(ITEMS + 100) * (2 * CON_CELLS + 2 * HOLD_CYCLES));

    logic clk = 1'b0;
    logic rst_n;

    tcw_cmd_if cmd_bus ();
    tcw_rsp_if rsp_bus ();
    tcw_cfg_if cfg_bus ();

    console_scoreboard board = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_done     = 0;
    int hold_left      = 0;
    int items_sent     = 0;

    int send_idle_tab [PHASES] = '{0, 64, 0, 14};
    int recv_stall_tab [PHASES] = '{0, 0, 64, 14};

    text_console_writer_top #(
        .COLUMNS(CON_COLS),
        .ROWS   (CON_ROWS)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_bus),
        .o_rsp  (rsp_bus),
        .i_cfg  (cfg_bus)
    );

    always #2 clk = ~clk;

    // response side: check each word, then pick ready for the next edge
    always @(posedge clk) begin
        if (rsp_bus.valid && rsp_bus.ready) begin
            board.check_rsp({rsp_bus.cursor_row, rsp_bus.cursor_col, rsp_bus.cell_char,
                             rsp_bus.cell_attr, rsp_bus.scrolled});
        end
        if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            // long hold-off so the block backs up and stalls its input
            rsp_bus.ready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            holds_done    <= holds_done + 1;
        end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // run limit
    initial begin : watchdog
        longint cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // offer one command word, with random idle cycles ahead of it
    task automatic send_cmd(logic [1:0] op, logic [7:0] ch, logic [4:0] row, logic [6:0] col);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.operation  <= op;
        cmd_bus.char_code  <= ch;
        cmd_bus.target_row <= row;
        cmd_bus.target_col <= col;
        @(posedge clk);
        while (!cmd_bus.ready) @(posedge clk);
        board.note_cmd(op, ch, row, col);
        items_sent++;
    endtask

    // stop offering and wait for every outstanding response
    task automatic wait_drained(int settle);
        cmd_bus.valid <= 1'b0;
        while (board.expected_rsp.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_attr(logic [7:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        cfg_bus.valid <= 1'b0;
        board.set_attr(value);
    endtask

    function automatic logic [7:0] pick_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) return CH_NEWLINE;
        if (sel < 14) return CH_BACKSPACE;
        if (sel < 34) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    // place the cursor, type a short run of text, read some of it back
    task automatic send_text_burst();
        logic [4:0]  row;
        logic [6:0]  col;
        int          back;
        int unsigned spot;
        row = ($urandom_range(0, 2) == 0) ? 5'(CON_ROWS - 1)
                                          : 5'($urandom_range(0, CON_ROWS - 1));
        col = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(CON_COLS - 6, CON_COLS - 1))
                                          : 7'($urandom_range(0, CON_COLS - 1));
        send_cmd(OP_SET_CURSOR, 8'($urandom), row, col);
        repeat ($urandom_range(1, 16))
            send_cmd(OP_WRITE_CHAR, pick_char(), 5'($urandom), 7'($urandom));
        repeat ($urandom_range(1, 3)) begin
            back = $urandom_range(0, 4);
            spot = (board.cursor > back) ? board.cursor - back : 0;
            send_cmd(OP_READ_CELL, 8'($urandom), 5'(spot / CON_COLS), 7'(spot % CON_COLS));
        end
    endtask

    // single command with fully random operands
    task automatic send_noise();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            send_cmd(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
        else if (sel < 40)
            send_cmd(OP_WRITE_CHAR, 8'($urandom), 5'($urandom), 7'($urandom));
        else if (sel < 60)
            send_cmd(OP_SET_CURSOR, 8'($urandom), 5'($urandom), 7'($urandom));
        else
            send_cmd(OP_READ_CELL, 8'($urandom), 5'($urandom), 7'($urandom));
    endtask

    // corner cases: empty store, backspace edges, saturation, scrolling, clear
    task automatic run_directed();
        send_cmd(OP_READ_CELL, 8'h00, 5'd0, 7'd0);
        send_cmd(OP_WRITE_CHAR, CH_BACKSPACE, 5'd0, 7'd0);
        send_cmd(OP_WRITE_CHAR, 8'h41, 5'd31, 7'd127);
        send_cmd(OP_WRITE_CHAR, 8'hFF, 5'd0, 7'd0);
        send_cmd(OP_WRITE_CHAR, 8'h00, 5'd0, 7'd0);
        send_cmd(OP_WRITE_CHAR, CH_BACKSPACE, 5'd0, 7'd0);
        send_cmd(OP_READ_CELL, 8'hFF, 5'd0, 7'd0);
        send_cmd(OP_READ_CELL, 8'h00, 5'd0, 7'd2);
        send_cmd(OP_WRITE_CHAR, CH_NEWLINE, 5'd0, 7'd0);
        // backspace at a row start wraps to the end of the row above
        send_cmd(OP_SET_CURSOR, 8'h00, 5'd3, 7'd0);
        send_cmd(OP_WRITE_CHAR, CH_BACKSPACE, 5'd0, 7'd0);
        send_cmd(OP_SET_CURSOR, 8'h00, 5'd31, 7'd127);
        send_cmd(OP_WRITE_CHAR, 8'h7E, 5'd0, 7'd0);
        send_cmd(OP_READ_CELL, 8'h00, 5'd23, 7'd79);
        send_cmd(OP_READ_CELL, 8'h00, 5'd24, 7'd79);
        send_cmd(OP_SET_CURSOR, 8'h00, 5'd24, 7'd5);
        send_cmd(OP_WRITE_CHAR, CH_NEWLINE, 5'd0, 7'd0);
        send_cmd(OP_READ_CELL, 8'h00, 5'd25, 7'd0);
        send_cmd(OP_READ_CELL, 8'h00, 5'd0, 7'd80);
        send_cmd(OP_READ_CELL, 8'h00, 5'd31, 7'd127);
        send_cmd(OP_SET_CURSOR, 8'h00, 5'd24, 7'd127);
        send_cmd(OP_SET_CURSOR, 8'h00, 5'd30, 7'd0);
        send_cmd(OP_CLEAR, 8'h00, 5'd0, 7'd0);
        send_cmd(OP_READ_CELL, 8'h00, 5'd12, 7'd40);
        send_cmd(OP_READ_CELL, 8'h00, 5'd24, 7'd79);
    endtask

    // main sequence
    initial begin
        int target;
        rst_n              = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.operation  = OP_WRITE_CHAR;
        cmd_bus.char_code  = CH_NULL;
        cmd_bus.target_row = '0;
        cmd_bus.target_col = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.data       = '0;
        rsp_bus.ready      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        // random phases, each with its own attribute and idle pattern
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained(SETTLE_CYCLES);
            if (phase == 0)
                write_attr(8'h00);
            else if (phase == 1)
                write_attr(8'hFF);
            else
                write_attr(8'($urandom));
            send_idle_pct  = send_idle_tab[phase];
            recv_stall_pct <= recv_stall_tab[phase];
            if (phase == 0 || phase == 3) hold_requests <= hold_requests + 1;
            target = items_sent + (ITEMS - DIRECTED) / PHASES;
            while (items_sent < target) begin
                if ($urandom_range(0, 9) < 6)
                    send_noise();
                else
                    send_text_burst();
            end
        end

        wait_drained(CON_CELLS + 16);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
sv/tcw_pkg.sv
sv/tcw_if.sv
sv/tcw_cell_mem.sv
sv/tcw_ctrl.sv
sv/text_console_writer_top.sv
test/testbench.sv
